/* rtl/core/bezier_curve_point_evaluator_assert.svh */
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator_assert
// Assertion macros for the Bezier curve point evaluator.
// ----------------------------------------------------------------------------
// Each macro checks a property at every rising edge of the given clock.
// The check is disabled while the active-low reset is asserted.
`ifndef BEZIER_CURVE_POINT_EVALUATOR_ASSERT_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCPE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bcpe_pkg.sv */
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the Bezier curve point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    // Size of the control point store.
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths.
    localparam int COORD_W  = 32;
    localparam int T_W      = 16;
    localparam int PIDX_W   = 4;
    localparam int DEG_W    = 4;
    localparam int DIM_W    = 2;

    // Parameter value standing for 1.0 in Q1.15.
    localparam logic [T_W-1:0] T_ONE = 16'h8000;

    // Input tdata layout, lowest bit first.
    localparam int S_PIDX_LSB = 0;
    localparam int S_X_LSB    = S_PIDX_LSB + PIDX_W;
    localparam int S_Y_LSB    = S_X_LSB + COORD_W;
    localparam int S_Z_LSB    = S_Y_LSB + COORD_W;
    localparam int S_T_LSB    = S_Z_LSB + COORD_W;
    localparam int S_USED_W   = S_T_LSB + T_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int M_X_LSB   = 0;
    localparam int M_Y_LSB   = M_X_LSB + COORD_W;
    localparam int M_Z_LSB   = M_Y_LSB + COORD_W;
    localparam int M_TDATA_W = M_Z_LSB + COORD_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_DEGREE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS   = 8'd1;
    localparam logic [DEG_W-1:0] DEG_RESET = 4'd3;
    localparam logic [DIM_W-1:0] DIM_3D    = 2'd3;

    // Operation codes carried in tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    // Sequencer commands to the working lines.
    typedef struct packed {
        logic             load;      // copy the store into the line
        logic             step;      // one interpolation step
        logic             shift2;    // last step of a triangle row
        logic [IDX_W-1:0] push_idx;  // where the new value is written
    } bcpe_ctrl_t;

    // Sequencer status toward the top level.
    typedef struct packed {
        logic idle;
        logic out_load;
    } bcpe_stat_t;

endpackage

/* rtl/core/bcpe_lerp.sv */
// ----------------------------------------------------------------------------
// bcpe_lerp
// Fixed point linear interpolation, (u*a + t*b + 2^14) >> 15 with u = 1 - t.
// ----------------------------------------------------------------------------
module bcpe_lerp
    import bcpe_pkg::*;
(
    input  coord_t         a,
    input  coord_t         b,
    input  logic [T_W-1:0] t,
    output coord_t         res
);

    // u*a + t*b equals a*2^15 + t*(b - a), so one multiplier does it.
    logic signed [COORD_W:0]         diff;
    logic signed [COORD_W+T_W+1:0]   prod;
    logic signed [COORD_W+T_W+1:0]   sum;

    assign diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
    assign prod = diff * $signed({1'b0, t});
    assign sum  = prod + (COORD_W + T_W + 2)'(16384);
    assign res  = a + coord_t'(sum[COORD_W+14:15]);

endmodule

/* rtl/core/bcpe_lane.sv */
// ----------------------------------------------------------------------------
// bcpe_lane
// One axis: the working line of the interpolation triangle and its lerp unit.
// ----------------------------------------------------------------------------
module bcpe_lane
    import bcpe_pkg::*;
(
    input  logic           aclk,
    input  bcpe_ctrl_t     ctrl,
    input  logic [T_W-1:0] t,
    input  coord_t         store [MAX_POINTS],
    output coord_t         head
);

    coord_t w_reg  [MAX_POINTS];
    coord_t w_next [MAX_POINTS];
    coord_t lerp_res;

    // Each step interpolates the two head entries of the current row.
    bcpe_lerp u_lerp (
        .a   (w_reg[0]),
        .b   (w_reg[1]),
        .t   (t),
        .res (lerp_res)
    );

    // The line works as a queue: the head is consumed and the new value is
    // appended at the row's tail. The last step of a row also drops the
    // row's final entry, so the line moves by two.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        coord_t shift1;
        coord_t shift2;
        if (i + 1 < MAX_POINTS) begin : g_s1
            assign shift1 = w_reg[i+1];
        end else begin : g_s1_end
            assign shift1 = w_reg[i];
        end
        if (i + 2 < MAX_POINTS) begin : g_s2
            assign shift2 = w_reg[i+2];
        end else begin : g_s2_end
            assign shift2 = w_reg[i];
        end

        always_comb begin
            w_next[i] = w_reg[i];
            if (ctrl.load) begin
                w_next[i] = store[i];
            end else if (ctrl.step) begin
                if (ctrl.push_idx == IDX_W'(i)) begin
                    w_next[i] = lerp_res;
                end else if (ctrl.shift2) begin
                    w_next[i] = shift2;
                end else begin
                    w_next[i] = shift1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            w_reg[i] <= w_next[i];
        end
    end

    assign head = w_reg[0];

endmodule

/* rtl/core/bcpe_seq.sv */
// ----------------------------------------------------------------------------
// bcpe_seq
// Sequencer that walks the interpolation triangle row by row.
// ----------------------------------------------------------------------------
module bcpe_seq
    import bcpe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DEG_W-1:0] degree,
    input  logic             out_free,
    output bcpe_ctrl_t       ctrl,
    output bcpe_stat_t       stat
);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] deg_eff;
    logic             row_end;

    // The degree cannot exceed what the store holds.
    assign deg_eff = (int'(degree) > MAX_POINTS - 1) ? IDX_W'(MAX_POINTS - 1)
                                                    : IDX_W'(degree);

    // A row of len entries takes len - 1 steps.
    assign row_end = ((CNT_W'(step_reg) + CNT_W'(2)) == len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        step_next     = step_reg;
        ctrl          = '0;
        stat.idle     = (state_reg == ST_IDLE);
        stat.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ctrl.load  = 1'b1;
                    len_next   = CNT_W'(deg_eff) + CNT_W'(1);
                    step_next  = '0;
                    state_next = (deg_eff == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                ctrl.step   = 1'b1;
                ctrl.shift2 = row_end;
                if (row_end) begin
                    ctrl.push_idx = IDX_W'(len_reg - CNT_W'(2));
                    step_next     = '0;
                    len_next      = len_reg - CNT_W'(1);
                    if (len_reg == CNT_W'(2)) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    ctrl.push_idx = IDX_W'(len_reg - CNT_W'(1));
                    step_next     = step_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    stat.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/bezier_curve_point_evaluator.sv */
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator
// Evaluates a Bezier curve of configurable degree by De Casteljau's method.
// ----------------------------------------------------------------------------
// A load transfer (tuser = 0) writes one control point into the 16-entry point
// store and produces no result; the block is ready again in the next cycle.
// An evaluate transfer (tuser = 1) takes the parameter t and produces one
// position. Evaluation keeps the block busy while the sequencer first copies
// the store into the working lines, then works each cell of the De Casteljau
// triangle as a step of the single lerp unit per axis, and finally hands the
// position to the output register. The three axes run side by side. The
// output register lets the next transfer be accepted while a result still
// waits on m_tready. If a second position finishes while the first one still
// waits, its hand-over is held until the output register frees, so
// back-pressure on the result stream adds to the busy time.
// Control points must be loaded before an evaluation reads them. In planar
// mode (dimensions other than 3) pos_z is zero. Parameters above 1.0 are
// treated as 1.0. Configuration writes are always accepted and must only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
`include "bezier_curve_point_evaluator_assert.svh"

module bezier_curve_point_evaluator
    import bcpe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_index, coord_x, coord_y, coord_z, param_t, zero padding
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [0:0]            s_tuser,
    input  logic                  s_tlast,

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pos_x, pos_y, pos_z
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,

    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DEG_W-1:0] degree_reg;
    logic [DIM_W-1:0] dims_reg;

    coord_t store_x [MAX_POINTS];
    coord_t store_y [MAX_POINTS];
    coord_t store_z [MAX_POINTS];

    logic [T_W-1:0]    t_reg;
    logic              last_reg;
    logic              m_tvalid_reg;
    logic              m_tlast_reg;
    coord_t            m_x_reg;
    coord_t            m_y_reg;
    coord_t            m_z_reg;

    logic              s_xfer;
    logic              load_xfer;
    logic              eval_xfer;
    logic              out_free;
    logic [PIDX_W-1:0] in_pidx;
    logic [T_W-1:0]    in_t;
    logic [T_W-1:0]    t_sat;
    bcpe_ctrl_t        ctrl;
    bcpe_stat_t        stat;
    coord_t            head_x;
    coord_t            head_y;
    coord_t            head_z;

    // Configuration registers. Writes to indexes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= DEG_RESET;
            dims_reg   <= DIM_3D;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CURVE_DEGREE: degree_reg <= cfg_data[DEG_W-1:0];
                CFG_DIMENSIONS:   dims_reg   <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input side: the block takes a transfer only while the sequencer idles.
    assign s_tready  = stat.idle;
    assign s_xfer    = s_tvalid && s_tready;
    assign load_xfer = s_xfer && (s_tuser[0] == OP_LOAD);
    assign eval_xfer = s_xfer && (s_tuser[0] == OP_EVAL);
    assign in_pidx   = s_tdata[S_PIDX_LSB +: PIDX_W];
    assign in_t      = s_tdata[S_T_LSB +: T_W];
    assign t_sat     = (in_t > T_ONE) ? T_ONE : in_t;

    // Point store. Loads past the end of the store are ignored.
    always_ff @(posedge aclk) begin
        if (load_xfer && (int'(in_pidx) < MAX_POINTS)) begin
            store_x[IDX_W'(in_pidx)] <= coord_t'(s_tdata[S_X_LSB +: COORD_W]);
            store_y[IDX_W'(in_pidx)] <= coord_t'(s_tdata[S_Y_LSB +: COORD_W]);
            store_z[IDX_W'(in_pidx)] <= coord_t'(s_tdata[S_Z_LSB +: COORD_W]);
        end
    end

    // The parameter and the batch marker are held for the whole evaluation.
    always_ff @(posedge aclk) begin
        if (eval_xfer) begin
            t_reg    <= t_sat;
            last_reg <= s_tlast;
        end
    end

    bcpe_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (eval_xfer),
        .degree   (degree_reg),
        .out_free (out_free),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    bcpe_lane u_lane_x (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .t     (t_reg),
        .store (store_x),
        .head  (head_x)
    );

    bcpe_lane u_lane_y (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .t     (t_reg),
        .store (store_y),
        .head  (head_y)
    );

    bcpe_lane u_lane_z (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .t     (t_reg),
        .store (store_z),
        .head  (head_z)
    );

    // Output register. A finished position moves in once the previous result
    // has been taken or is being taken in the same cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (stat.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.out_load) begin
            m_x_reg     <= head_x;
            m_y_reg     <= head_y;
            m_z_reg     <= (dims_reg == DIM_3D) ? head_z : '0;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_z_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_tlast_reg;

    // An evaluate transfer makes the block busy.
    `BCPE_ASSERT_NEXT(a_eval_busy, aclk, aresetn, eval_xfer, !s_tready,
        "evaluate transfer did not make the block busy")
    // A load completes in its own cycle.
    `BCPE_ASSERT_NEXT(a_load_quick, aclk, aresetn, load_xfer, s_tready,
        "load transfer kept the block busy")
    // A finished result always reaches the output register.
    `BCPE_ASSERT_NEXT(a_result_out, aclk, aresetn, stat.out_load, m_tvalid,
        "finished result was not presented")
    // A result only moves in when the output register can take it.
    `BCPE_ASSERT_SAME(a_no_overwrite, aclk, aresetn, stat.out_load,
        !m_tvalid || m_tready, "result overwrote a waiting result")

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the Bezier curve point evaluator.
// ----------------------------------------------------------------------------
// Control points are loaded and positions are requested over the input
// stream. Each accepted transfer also goes through a De Casteljau predictor
// kept inside this module. Every evaluation queues one expected position,
// and each result transfer is compared with the oldest one, field by field.
// A short table of directed rows covers the corners first: the coordinate
// extremes, t at 0, 1.0 and above 1.0, planar mode, degree zero and ignored
// register writes. After that, random phases follow, each one with its own
// degree and dimension setting. Both sides insert random gaps. In one phase
// the receiver holds off long enough for the input to back up.
// ----------------------------------------------------------------------------
module tb_top
    import bcpe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Margin for the longest evaluation, at degree 15.
    localparam int BUSY_MAX    = 130;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int N_PHASES    = 14;
    localparam int PHASE_ITEMS = 57;
    localparam int N_DIRECTED  = 26;

    // Register indexes outside the list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

    localparam coord_t C_MAX = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN = 32'sh8000_0000;

    // Control points of the directed part.
    localparam coord_t P0X = C_MAX,          P0Y = C_MIN,          P0Z = 32'sh0001_0000;
    localparam coord_t P1X = 32'sh1234_5678, P1Y = 32'shF543_2110, P1Z = 32'sh0000_0000;
    localparam coord_t P2X = C_MIN,          P2Y = C_MAX,          P2Z = 32'shFFFF_FFFF;
    localparam coord_t P3X = 32'sh0000_0001, P3Y = 32'shFFFF_0000, P3Z = C_MAX;
    localparam coord_t PFX = 32'shFFFF_FFFF, PFY = 32'sh0000_0000, PFZ = C_MIN;

    typedef struct packed {
        logic               op;
        logic [PIDX_W-1:0]  pidx;
        coord_t             x;
        coord_t             y;
        coord_t             z;
        logic [T_W-1:0]     t;
        logic               last;
    } stim_item_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } pos_t;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_EVAL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    cidx;
        logic [CFG_DATA_W-1:0]   cdata;
        stim_item_t              it;
        logic                    typed;  // want holds a position read off by hand
        pos_t                    want;
    } dir_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    bezier_curve_point_evaluator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the control point store and the two registers.
    // ------------------------------------------------------------------------
    coord_t                  ctrl_x [MAX_POINTS];
    coord_t                  ctrl_y [MAX_POINTS];
    coord_t                  ctrl_z [MAX_POINTS];
    logic [MAX_POINTS-1:0]   ctrl_loaded = '0;
    logic [DEG_W-1:0]        deg_reg     = DEG_RESET;
    logic [DIM_W-1:0]        dim_reg     = DIM_3D;

    pos_t      pending_pos [$];
    dir_row_t  directed_rows [N_DIRECTED];

    int  err_count   = 0;
    int  item_count  = 0;
    int  n_loads     = 0;
    int  n_evals     = 0;
    int  n_regs      = 0;
    int  n_checked   = 0;
    bit  tx_free     = 1'b0;   // sender offers items back to back
    bit  rx_free     = 1'b0;   // receiver never stalls
    int  hold_grants = 0;      // raised by the stimulus to ask for a long hold-off
    int  hold_seen   = 0;
    int  hold_left   = 0;
    int  stall_left  = 0;
    int  quiet_cycles = 0;

    // One interpolation step in Q1.15: (u*a + t*b + 2^14) >>> 15.
    function automatic coord_t blend_q15(input coord_t a, input coord_t b,
                                         input logic [T_W-1:0] t);
        longint wa, wb, wt, acc;
        wa  = a;
        wb  = b;
        wt  = t;
        acc = (64'sd32768 - wt) * wa + wt * wb + 64'sd16384;
        return coord_t'(acc >>> 15);
    endfunction

    // Collapses the De Casteljau triangle of one axis down to its apex.
    function automatic coord_t sweep_axis(input coord_t pts [MAX_POINTS], input int deg,
                                          input logic [T_W-1:0] t);
        coord_t w [MAX_POINTS];
        int r, k;
        for (k = 0; k <= deg; k++) w[k] = pts[k];
        for (r = 1; r <= deg; r++)
            for (k = 0; k + r <= deg; k++) w[k] = blend_q15(w[k], w[k + 1], t);
        return w[0];
    endfunction

    // Applies one accepted item to the predictor. Loads update the store;
    // evaluations return the expected position.
    task automatic predict_position(input stim_item_t it, output bit produces,
                                    output pos_t p);
        logic [T_W-1:0] t;
        int deg;
        p = '0;
        produces = 1'b0;
        if (it.op == OP_LOAD) begin
            ctrl_x[it.pidx] = it.x;
            ctrl_y[it.pidx] = it.y;
            ctrl_z[it.pidx] = it.z;
            ctrl_loaded[it.pidx] = 1'b1;
        end else begin
            t   = (it.t > T_ONE) ? T_ONE : it.t;
            deg = (deg_reg > MAX_POINTS - 1) ? MAX_POINTS - 1 : int'(deg_reg);
            p.x = sweep_axis(ctrl_x, deg, t);
            p.y = sweep_axis(ctrl_y, deg, t);
            p.z = (dim_reg == DIM_3D) ? sweep_axis(ctrl_z, deg, t) : '0;
            p.last = it.last;
            produces = 1'b1;
        end
    endtask

    // True when every control point that an evaluation would read has been
    // written since reset.
    function automatic bit points_ready();
        for (int k = 0; k <= int'(deg_reg); k++)
            if (!ctrl_loaded[k]) return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows.
    // ------------------------------------------------------------------------
    function automatic dir_row_t row_load(input logic [PIDX_W-1:0] idx,
                                          input coord_t x, input coord_t y, input coord_t z);
        dir_row_t r;
        r = '0;
        r.kind    = ROW_LOAD;
        r.it.op   = OP_LOAD;
        r.it.pidx = idx;
        r.it.x    = x;
        r.it.y    = y;
        r.it.z    = z;
        return r;
    endfunction

    function automatic dir_row_t row_eval(input logic [T_W-1:0] t, input logic last);
        dir_row_t r;
        r = '0;
        r.kind    = ROW_EVAL;
        r.it.op   = OP_EVAL;
        r.it.t    = t;
        r.it.last = last;
        return r;
    endfunction

    function automatic dir_row_t row_eval_is(input logic [T_W-1:0] t, input logic last,
                                             input coord_t x, input coord_t y,
                                             input coord_t z);
        dir_row_t r;
        r = row_eval(t, last);
        r.typed     = 1'b1;
        r.want.x    = x;
        r.want.y    = y;
        r.want.z    = z;
        r.want.last = last;
        return r;
    endfunction

    function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r = '0;
        r.kind  = ROW_CFG;
        r.cidx  = idx;
        r.cdata = data;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random values.
    // ------------------------------------------------------------------------
    function automatic coord_t rand_coord();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return C_MAX;
                1:       return C_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return coord_t'($urandom);
    endfunction

    function automatic logic [T_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return T_ONE;
                    2:       return '1;
                    3:       return T_ONE - 1;
                    default: return 16'd1;
                endcase
            end
            1:       return T_W'($urandom_range(32769, 65535));
            default: return T_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic stim_item_t rand_load();
        stim_item_t it;
        it.op   = OP_LOAD;
        it.pidx = PIDX_W'($urandom_range(0, MAX_POINTS - 1));
        it.x    = rand_coord();
        it.y    = rand_coord();
        it.z    = rand_coord();
        it.t    = T_W'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    // An evaluation with junk in the coordinate fields. While the store still
    // has holes at or below the current degree, the lowest hole is loaded instead.
    function automatic stim_item_t rand_eval();
        stim_item_t it;
        it = rand_load();
        if (!points_ready()) begin
            for (int k = MAX_POINTS - 1; k >= 0; k--)
                if (!ctrl_loaded[k]) it.pidx = PIDX_W'(k);
            return it;
        end
        it.op = OP_EVAL;
        it.t  = rand_param();
        return it;
    endfunction

    function automatic int tx_gap();
        int r;
        if (tx_free) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------
    // Offers one item and waits for its transfer. tvalid is left high so that
    // a following item without a gap goes out in the next cycle.
    task automatic send_item(input stim_item_t it, input bit typed, input pos_t want);
        logic [S_TDATA_W-1:0] word;
        int gap;
        bit produces;
        pos_t p;
        gap = tx_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[S_PIDX_LSB +: PIDX_W] = it.pidx;
        word[S_X_LSB +: COORD_W]   = it.x;
        word[S_Y_LSB +: COORD_W]   = it.y;
        word[S_Z_LSB +: COORD_W]   = it.z;
        word[S_T_LSB +: T_W]       = it.t;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= it.op;
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        predict_position(it, produces, p);
        if (produces) pending_pos.push_back(typed ? want : p);
        item_count++;
        if (it.op == OP_EVAL) n_evals++;
        else n_loads++;
    endtask

    // Register write. cfg_valid stays high; the caller lowers it after the
    // last write of a group.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_CURVE_DEGREE) deg_reg = data[DEG_W-1:0];
        else if (idx == CFG_DIMENSIONS) dim_reg = data[DIM_W-1:0];
        n_regs++;
    endtask

    // Stops offering items, waits for every outstanding position, then lets
    // a full evaluation time pass so that nothing is left in flight.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge aclk);
        repeat (BUSY_MAX) @(posedge aclk);
    endtask

    task automatic run_phase(input int quota);
        int start, nload, nbatch, k;
        stim_item_t it;
        start = item_count;
        while (item_count - start < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                // Refresh a few control points, then a batch of parameters.
                nload = $urandom_range(0, 3);
                for (k = 0; k < nload; k++) send_item(rand_load(), 1'b0, '0);
                nbatch = $urandom_range(1, 6);
                for (k = 0; k < nbatch; k++) begin
                    it = rand_eval();
                    it.last = (k == nbatch - 1);
                    send_item(it, 1'b0, '0);
                end
            end else begin
                it = $urandom_range(0, 1) ? rand_eval() : rand_load();
                it.last = 1'($urandom);
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, quiet stretches, and the long hold-off that
    // makes the block back up into its input.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : rx_side
        logic rdy;
        if (hold_seen != hold_grants) begin
            hold_seen = hold_grants;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (rx_free) begin
            rdy = 1'b1;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) - 1
                                                     : $urandom_range(1, 4) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_tready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    always @(posedge aclk) begin : result_monitor
        pos_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x    = m_tdata[M_X_LSB +: COORD_W];
            got.y    = m_tdata[M_Y_LSB +: COORD_W];
            got.z    = m_tdata[M_Z_LSB +: COORD_W];
            got.last = m_tlast;
            if (pending_pos.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%h y=%h z=%h last=%b",
                                          got.x, got.y, got.z, got.last));
            end else begin
                want = pending_pos.pop_front();
                check_field("pos_x", got.x, want.x);
                check_field("pos_y", got.y, want.y);
                check_field("pos_z", got.z, want.z);
                check_field("batch_last", 32'(got.last), 32'(want.last));
                n_checked++;
            end
        end
    end

    // Watchdog: a correct run never goes this long without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d positions outstanding",
                     quiet_cycles, pending_pos.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int i, p, deg, dim;

        // At t = 0 the triangle collapses onto point 0, at t >= 1.0 onto the
        // point at the degree; those rows carry their results typed in.
        directed_rows = '{
            row_load(4'd0,  P0X, P0Y, P0Z),
            row_load(4'd1,  P1X, P1Y, P1Z),
            row_load(4'd2,  P2X, P2Y, P2Z),
            row_load(4'd3,  P3X, P3Y, P3Z),
            row_load(4'd15, PFX, PFY, PFZ),
            row_eval_is(16'h0000, 1'b0, P0X, P0Y, P0Z),
            row_eval_is(16'h8000, 1'b1, P3X, P3Y, P3Z),
            row_eval_is(16'hFFFF, 1'b1, P3X, P3Y, P3Z),
            row_eval   (16'h4000, 1'b0),
            row_eval_is(16'h8001, 1'b0, P3X, P3Y, P3Z),
            row_eval   (16'h0001, 1'b0),
            row_eval   (16'h7FFF, 1'b1),
            row_cfg(CFG_DIMENSIONS, 8'd2),
            row_eval_is(16'h0000, 1'b1, P0X, P0Y, '0),
            row_eval   (16'h5555, 1'b0),
            // Only the low four bits of the data reach the degree register.
            row_cfg(CFG_CURVE_DEGREE, 8'h12),
            row_eval_is(16'h8000, 1'b1, P2X, P2Y, '0),
            row_eval   (16'h2AAA, 1'b0),
            row_cfg(CFG_CURVE_DEGREE, 8'd0),
            row_cfg(CFG_DIMENSIONS, 8'd3),
            row_eval_is(16'h6000, 1'b1, P0X, P0Y, P0Z),
            row_cfg(CFG_IDX_SPARE, 8'hFF),
            row_cfg(CFG_IDX_TOP, 8'h00),
            row_eval_is(16'h8000, 1'b0, P0X, P0Y, P0Z),
            row_cfg(CFG_DIMENSIONS, 8'd1),
            row_eval_is(16'h1234, 1'b1, P0X, P0Y, '0)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (i == 0 || directed_rows[i - 1].kind != ROW_CFG) settle_block();
                write_register(directed_rows[i].cidx, directed_rows[i].cdata);
                if (i == N_DIRECTED - 1 || directed_rows[i + 1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end else begin
                send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases. The first ones pin the degree and dimension extremes;
        // the later ones lean toward small degrees to keep the run short.
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       begin deg = 15; dim = 3; end
                1:       begin deg = 0;  dim = 2; end
                2:       begin deg = 1;  dim = 3; end
                3:       begin deg = 15; dim = 2; end
                4:       begin deg = 2;  dim = 3; end
                default: begin
                    deg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 4);
                    case ($urandom_range(0, 9))
                        0:       dim = $urandom_range(0, 1);
                        1, 2, 3: dim = 2;
                        default: dim = 3;
                    endcase
                end
            endcase
            settle_block();
            write_register(CFG_CURVE_DEGREE, CFG_DATA_W'(deg));
            write_register(CFG_DIMENSIONS, CFG_DATA_W'(dim));
            cfg_valid <= 1'b0;
            tx_free = (p == 4) || (p % 5 == 2);
            rx_free = (p % 4 == 1);
            // Back-pressure phase: the receiver goes quiet while items keep
            // coming, so the output register and the evaluator both fill.
            if (p == 4) hold_grants++;
            run_phase(PHASE_ITEMS);
        end

        settle_block();

        $display("Covered %0d control point loads, %0d evaluations and %0d register writes,",
                 n_loads, n_evals, n_regs);
        $display("degrees 0 to 15, planar and spatial; %0d positions checked, %0d mismatches.",
                 n_checked, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
